// ===== rtl/core/tcw_pkg.sv =====
// tcw_pkg: shared constants, codes and beat types for the text console writer
// no dependencies; used by tcw_front, tcw_back and text_console_writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int CW         = $clog2(COLUMNS + 1);
    localparam int TAB_STOP   = 4;

    // character codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;

    // attribute and cell after reset
    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

    // item op codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // command kinds handed from front to back
    localparam logic [2:0] K_CHAR  = 3'd0;
    localparam logic [2:0] K_NL    = 3'd1;
    localparam logic [2:0] K_CR    = 3'd2;
    localparam logic [2:0] K_TAB   = 3'd3;
    localparam logic [2:0] K_CLEAR = 3'd4;
    localparam logic [2:0] K_READ  = 3'd5;
    localparam logic [2:0] K_NOP   = 3'd6;

    // command queue
    localparam int Q_DEPTH = 2;
    localparam int QAW     = (Q_DEPTH > 2) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [10:0] idx;
        logic        in_range;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic init;
    } t_back_stat;

endpackage

// ===== rtl/core/tcw_front.sv =====
// tcw_front: accepts items, classifies them into commands and queues them
// depends on tcw_pkg
module tcw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tcw_pkg::t_in       i_item,
    input  tcw_pkg::t_back_stat i_stat,
    output logic               o_busy,
    output logic               o_q_valid,
    output tcw_pkg::t_cmd      o_q_cmd
);

    tcw_pkg::t_cmd                 r_q [tcw_pkg::Q_DEPTH];
    logic [tcw_pkg::QAW-1:0]       r_wp, r_rp, n_wp, n_rp;
    logic [tcw_pkg::QCW-1:0]       r_count;
    tcw_pkg::t_cmd                 cmd;
    logic                          accept;
    logic                          pop;

    always_comb begin
        cmd.ch       = i_item.char_code;
        cmd.idx      = i_item.cell_index;
        cmd.in_range = 32'(i_item.cell_index) < tcw_pkg::CELL_COUNT;
        case (i_item.op)
            tcw_pkg::OP_PUT: begin
                case (i_item.char_code)
                    tcw_pkg::CH_NEWLINE: cmd.kind = tcw_pkg::K_NL;
                    tcw_pkg::CH_RETURN:  cmd.kind = tcw_pkg::K_CR;
                    tcw_pkg::CH_TAB:     cmd.kind = tcw_pkg::K_TAB;
                    default:             cmd.kind = tcw_pkg::K_CHAR;
                endcase
            end
            tcw_pkg::OP_CLEAR: cmd.kind = tcw_pkg::K_CLEAR;
            tcw_pkg::OP_READ:  cmd.kind = tcw_pkg::K_READ;
            default:           cmd.kind = tcw_pkg::K_NOP;
        endcase
    end

    assign o_busy    = (r_count == tcw_pkg::QCW'(tcw_pkg::Q_DEPTH)) || i_stat.init;
    assign accept    = i_start && !o_busy;
    assign o_q_valid = (r_count != '0);
    assign o_q_cmd   = r_q[r_rp];
    assign pop       = i_stat.take && o_q_valid;

    assign n_wp = (r_wp == tcw_pkg::QAW'(tcw_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == tcw_pkg::QAW'(tcw_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (accept) r_wp <= n_wp;
            if (pop)    r_rp <= n_rp;
            if (accept && !pop)      r_count <= r_count + 1'b1;
            else if (pop && !accept) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_q[r_wp] <= cmd;
    end

endmodule

// ===== rtl/core/tcw_back.sv =====
// tcw_back: executes queued commands against the screen memory and cursor
// depends on tcw_pkg; holds the cell memory, scroll and clear sweeps
module tcw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_attr,
    input  logic                i_q_valid,
    input  tcw_pkg::t_cmd       i_q_cmd,
    output tcw_pkg::t_back_stat o_stat,
    output logic                o_done,
    output tcw_pkg::t_out       o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WR     = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_CLR    = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int AW = tcw_pkg::AW;
    localparam int RW = tcw_pkg::RW;
    localparam int CW = tcw_pkg::CW;

    logic [15:0]   mem [tcw_pkg::CELL_COUNT];
    logic [15:0]   r_rdata;

    logic [2:0]    r_state, n_state;
    tcw_pkg::t_cmd r_cmd, n_cmd;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_init, n_init;
    logic          r_cp_valid;
    logic [AW-1:0] r_cp_addr;

    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic [AW-1:0] ra;
    logic [CW-1:0] col_inc;
    logic          pend_wr;

    assign col_inc = r_col + 1'b1;
    assign pend_wr = (r_cmd.kind == tcw_pkg::K_CHAR) || (r_cmd.kind == tcw_pkg::K_TAB);
    assign ra      = (r_state == S_SCROLL) ? r_cnt : AW'(r_cmd.idx);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_row   = r_row;
        n_col   = r_col;
        n_base  = r_base;
        n_cnt   = r_cnt;
        n_init  = r_init;
        we      = 1'b0;
        wa      = r_cnt;
        wd      = {i_attr, tcw_pkg::CH_SPACE};
        o_stat.take = 1'b0;
        o_stat.init = r_init;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_stat.take = 1'b1;
                    n_cmd       = i_q_cmd;
                    case (i_q_cmd.kind)
                        tcw_pkg::K_NL, tcw_pkg::K_CHAR, tcw_pkg::K_TAB: begin
                            if (i_q_cmd.kind != tcw_pkg::K_NL &&
                                32'(r_col) < tcw_pkg::COLUMNS) begin
                                n_state = S_WR;
                            end else if (r_row < RW'(tcw_pkg::ROWS - 1)) begin
                                // next line without scrolling
                                n_row   = r_row + 1'b1;
                                n_base  = r_base + AW'(tcw_pkg::COLUMNS);
                                n_col   = '0;
                                n_state = (i_q_cmd.kind == tcw_pkg::K_NL) ? S_OUT : S_WR;
                            end else begin
                                n_col   = '0;
                                n_cnt   = AW'(tcw_pkg::COLUMNS);
                                n_state = S_SCROLL;
                            end
                        end
                        tcw_pkg::K_CR: begin
                            n_col   = '0;
                            n_state = S_OUT;
                        end
                        tcw_pkg::K_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_cnt   = '0;
                            n_state = S_CLR;
                        end
                        tcw_pkg::K_READ: begin
                            n_state = i_q_cmd.in_range ? S_RD : S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_WR: begin
                we    = 1'b1;
                wa    = r_base + AW'(r_col);
                wd    = {i_attr, (r_cmd.kind == tcw_pkg::K_TAB) ? tcw_pkg::CH_SPACE
                                                                : r_cmd.ch};
                n_col = col_inc;
                // tab keeps padding until a stop or the row end
                if (!(r_cmd.kind == tcw_pkg::K_TAB &&
                      (col_inc % CW'(tcw_pkg::TAB_STOP)) != '0 &&
                      32'(col_inc) < tcw_pkg::COLUMNS)) begin
                    n_state = S_OUT;
                end
            end
            S_SCROLL: begin
                // read issued here, copy written in the following cycle
                if (r_cnt == AW'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_cnt   = AW'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS);
                    n_state = S_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_BLANK: begin
                if (!r_cp_valid) begin
                    we = 1'b1;
                    if (r_cnt == AW'(tcw_pkg::CELL_COUNT - 1)) begin
                        n_state = pend_wr ? S_WR : S_OUT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_CLR: begin
                we = 1'b1;
                if (r_init) wd = tcw_pkg::RESET_CELL;
                if (r_cnt == AW'(tcw_pkg::CELL_COUNT - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RD:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase

        if (r_cp_valid) begin
            we = 1'b1;
            wa = r_cp_addr;
            wd = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_init     <= 1'b1;
            r_cnt      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_base     <= '0;
            r_cp_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_cnt      <= n_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            r_base     <= n_base;
            r_cp_valid <= (r_state == S_SCROLL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cp_addr <= r_cnt - AW'(tcw_pkg::COLUMNS);
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rdata <= mem[ra];
    end

    assign o_done              = (r_state == S_OUT);
    assign o_result.cell_value = (r_cmd.kind == tcw_pkg::K_READ && r_cmd.in_range)
                                 ? r_rdata : 16'd0;
    assign o_result.cursor_row = 5'(r_row);
    assign o_result.cursor_col = 7'(r_col);

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text_console_writer: top level, attribute register and front/back pairing
// depends on tcw_pkg, tcw_front, tcw_back
//
// channel   | signals                  | handshake
// ----------+--------------------------+----------------------------------
// item in   | start, busy, i_item      | beat when start && !busy
// result    | o_done, o_result         | one-cycle strobe, no back-pressure
// config    | i_cfg_we, i_cfg_data     | written on any edge with i_cfg_we
//
// a put writes one cell, a tab pads up to the next stop, a read fetches one cell;
// one item is in the back at a time with two more queued in front
// a newline on the bottom row scrolls through the single cell memory, one cell a cycle,
// and a character that wraps there scrolls and is then written; a clear sweeps every cell
// after reset a clearing pass over all ROWS*COLUMNS cells runs with busy high
// busy rises when the queue is full and during that pass; results cannot be stalled
module text_console_writer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tcw_pkg::t_in  i_item,
    output logic          o_done,
    output tcw_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data
);

    logic [7:0]          r_attr;
    logic                q_valid;
    tcw_pkg::t_cmd       q_cmd;
    tcw_pkg::t_back_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    tcw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_stat    (stat),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd)
    );

    tcw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_attr    (r_attr),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_stat    (stat),
        .o_done    (o_done),
        .o_result  (o_result)
    );

`ifndef SYNTH
    // clearing pass holds the input off right after reset
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.cursor_row < 5'(tcw_pkg::ROWS)))
        else $error("cursor row beyond screen");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.cursor_col <= 7'(tcw_pkg::COLUMNS)))
        else $error("cursor column beyond pending wrap");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for text_console_writer, driving put, clear and read beats
// depends on tcw_pkg and the rtl in rtl/core; keeps a shadow screen to predict every result
module tb;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 150;

    class console_scoreboard;
        logic [15:0]   cells [tcw_pkg::CELL_COUNT];
        int            row;
        int            col;
        logic [7:0]    attr;
        tcw_pkg::t_out pending_results [$];
        int            mismatches;

        function new();
            attr       = tcw_pkg::ATTR_RESET;
            row        = 0;
            col        = 0;
            mismatches = 0;
            blank_screen();
        endfunction

        function void blank_screen();
            for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) cells[i] = {attr, tcw_pkg::CH_SPACE};
        endfunction

        function void scroll_up();
            for (int i = tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
                cells[i - tcw_pkg::COLUMNS] = cells[i];
            for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
                cells[i] = {attr, tcw_pkg::CH_SPACE};
        endfunction

        function void line_feed();
            if (row < tcw_pkg::ROWS - 1) row++;
            else scroll_up();
            col = 0;
        endfunction

        function void store_char(logic [7:0] ch);
            int idx;
            idx = row * tcw_pkg::COLUMNS + col;
            if (col < tcw_pkg::COLUMNS && idx < tcw_pkg::CELL_COUNT) cells[idx] = {attr, ch};
            col++;
        endfunction

        function void put_char(logic [7:0] ch);
            int pad;
            if (ch == tcw_pkg::CH_NEWLINE) begin
                line_feed();
            end else if (ch == tcw_pkg::CH_RETURN) begin
                col = 0;
            end else if (ch == tcw_pkg::CH_TAB) begin
                // lazy wrap first, then pad up to the next stop but never past the row
                if (col >= tcw_pkg::COLUMNS) line_feed();
                pad = tcw_pkg::TAB_STOP - (col % tcw_pkg::TAB_STOP);
                while (pad != 0 && col < tcw_pkg::COLUMNS) begin
                    store_char(tcw_pkg::CH_SPACE);
                    pad--;
                end
            end else begin
                if (col >= tcw_pkg::COLUMNS) line_feed();
                store_char(ch);
            end
        endfunction

        function void note_item(tcw_pkg::t_in it);
            tcw_pkg::t_out res;
            res = '0;
            case (it.op)
                tcw_pkg::OP_PUT: put_char(it.char_code);
                tcw_pkg::OP_CLEAR: begin
                    blank_screen();
                    row = 0;
                    col = 0;
                end
                tcw_pkg::OP_READ: begin
                    if (it.cell_index < tcw_pkg::CELL_COUNT)
                        res.cell_value = cells[it.cell_index];
                end
                default: ;
            endcase
            res.cursor_row = row[4:0];
            res.cursor_col = col[6:0];
            pending_results.push_back(res);
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(tcw_pkg::t_out got);
            tcw_pkg::t_out want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, expected none actual %h",
                         $time, got);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_value !== want.cell_value)
                report("cell_value", want.cell_value, got.cell_value);
            if (got.cursor_row !== want.cursor_row)
                report("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    tcw_pkg::t_in  i_item;
    logic          o_done;
    tcw_pkg::t_out o_result;
    logic          i_cfg_we;
    logic [7:0]    i_cfg_data;

    console_scoreboard sb = new();
    bit idling_on = 1'b1;
    int quiet_cycles = 0;

    text_console_writer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // no beat in either direction for too long means the block hung
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    function automatic tcw_pkg::t_in make_item(logic [1:0] op, logic [7:0] ch,
                                               logic [10:0] idx);
        tcw_pkg::t_in it;
        it.op         = op;
        it.char_code  = ch;
        it.cell_index = idx;
        return it;
    endfunction

    // nl_pct sets how often lines end; a low value fills rows and forces wraps
    function automatic tcw_pkg::t_in pick_item(int nl_pct);
        tcw_pkg::t_in it;
        int           p;
        int           near;
        it.op         = tcw_pkg::OP_PUT;
        it.char_code  = 8'($urandom_range(0, 255));
        it.cell_index = 11'($urandom_range(0, 2047));
        p = $urandom_range(0, 99);
        if (p < nl_pct) begin
            it.char_code = tcw_pkg::CH_NEWLINE;
        end else if (p < 2 * nl_pct) begin
            it.char_code = tcw_pkg::CH_RETURN;
        end else if (p < 2 * nl_pct + 1) begin
            it.op = tcw_pkg::OP_CLEAR;
        end else if (p < 2 * nl_pct + 9) begin
            it.char_code = tcw_pkg::CH_TAB;
        end else if (p < 2 * nl_pct + 19) begin
            // look just behind the cursor where fresh cells were written
            it.op = tcw_pkg::OP_READ;
            near = sb.row * tcw_pkg::COLUMNS + sb.col - $urandom_range(0, 4);
            it.cell_index = (near < 0) ? 11'd0 : near[10:0];
        end else if (p < 2 * nl_pct + 27) begin
            it.op = tcw_pkg::OP_READ;
        end else if (p < 2 * nl_pct + 30) begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    task automatic send_item(input tcw_pkg::t_in it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (idling_on && $urandom_range(0, 99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        drain_results();
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        sb.attr = value;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] attr_plan [PHASES];
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        attr_plan[0] = 8'hFF;
        attr_plan[1] = 8'h00;
        for (int k = 2; k < PHASES; k++) attr_plan[k] = 8'($urandom_range(0, 255));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset contents, range edges, unused op
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'hFF, 11'(tcw_pkg::CELL_COUNT - 1)));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::CELL_COUNT)));
        send_item(make_item(tcw_pkg::OP_READ, 8'hFF, 11'h7FF));
        send_item(make_item(OP_NONE, 8'hFF, 11'h7FF));
        // byte zero is a plain character
        send_item(make_item(tcw_pkg::OP_PUT, 8'h00, 11'h7FF));
        send_item(make_item(tcw_pkg::OP_PUT, 8'hFF, 11'd0));
        send_item(make_item(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 11'd0));
        send_item(make_item(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'd5));
        send_item(make_item(tcw_pkg::OP_PUT, tcw_pkg::CH_RETURN, 11'd0));
        send_item(make_item(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0));
        write_attr(8'hFF);
        send_item(make_item(tcw_pkg::OP_PUT, 8'h41, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::COLUMNS)));
        send_item(make_item(tcw_pkg::OP_CLEAR, 8'h00, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'(tcw_pkg::CELL_COUNT - 1)));
        write_attr(8'h00);
        send_item(make_item(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 11'd0));
        send_item(make_item(tcw_pkg::OP_PUT, 8'h7E, 11'd0));
        send_item(make_item(tcw_pkg::OP_READ, 8'h00, 11'd1));

        for (int ph = 0; ph < PHASES; ph++) begin
            write_attr(attr_plan[ph]);
            idling_on = !(ph == 4 || ph == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
                send_item(pick_item((ph % 2 == 1) ? 6 : 1));
            end
        end

        drain_results();
        if (sb.mismatches == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("FAIL text_console_writer");
        end
        $finish;
    end

endmodule
